[rtl/cpq_pkg.sv]
// shared types and constants for the class priority queue
`default_nettype none
package cpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int TAG_W           = 8;
  localparam int CLASS_W         = 2;
  localparam int TIME_W          = 16;
  localparam int ITEMS_W         = 5;
  localparam int CLASS_N         = 4;
  localparam int SERVED_W        = $clog2(MAX_RESULTS + 1);
  localparam logic [TIME_W-1:0] BUDGET_RESET = 16'd360;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DRAIN   = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    RES_ENQUEUED = 2'd0,
    RES_FULL     = 2'd1,
    RES_SERVED   = 2'd2,
    RES_NONE     = 2'd3
  } result_code_t;

  // one stored queue entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [CLASS_W-1:0] cls;
    logic [TIME_W-1:0]  time_units;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic insert;
    logic reject;
    logic serve;
    logic none;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic in_is_drain;
    logic full;
    logic can_serve;
    logic serve_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/cpq_if.sv]
// valid/ready channel interfaces for the input items and the results
`default_nettype none
interface cpq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  item_tag;
  logic [1:0]  member_class;
  logic [15:0] service_time;

  modport source (output valid, command, item_tag, member_class, service_time,
                  input ready);
  modport sink   (input valid, command, item_tag, member_class, service_time,
                  output ready);
endinterface

interface cpq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [7:0]  served_tag;
  logic [1:0]  served_class;
  logic [15:0] served_time;
  logic [4:0]  items_left;
  logic        last_result;

  modport source (output valid, result_code, served_tag, served_class, served_time,
                  items_left, last_result, input ready);
  modport sink   (input valid, result_code, served_tag, served_class, served_time,
                  items_left, last_result, output ready);
endinterface
`default_nettype wire

[rtl/cpq_ctrl.sv]
// controller state machine for enqueue and drain sequencing
`default_nettype none
module cpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpq_pkg::dp_stat_t   stat,
  output cpq_pkg::ctrl_cmd_t  cmd
);
  import cpq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ENQ   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = stat.in_is_drain ? ST_DRAIN : ST_ENQ;
        end
      end
      ST_ENQ: begin
        if (stat.out_free) begin
          if (stat.full) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.insert = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          if (stat.can_serve) begin
            cmd.serve = 1'b1;
            if (stat.serve_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            // head over budget or queue empty on the first look
            cmd.none  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/cpq_dp.sv]
// datapath: ordered entry shift array, class counters, budget sum and result register
`default_nettype none
module cpq_dp #(
  parameter int QUEUE_DEPTH = cpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpq_pkg::ctrl_cmd_t            cmd,
  output cpq_pkg::dp_stat_t             stat,
  input  logic                          in_command,
  input  logic [cpq_pkg::TAG_W-1:0]     in_item_tag,
  input  logic [cpq_pkg::CLASS_W-1:0]   in_member_class,
  input  logic [cpq_pkg::TIME_W-1:0]    in_service_time,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_result_code,
  output logic [cpq_pkg::TAG_W-1:0]     out_served_tag,
  output logic [cpq_pkg::CLASS_W-1:0]   out_served_class,
  output logic [cpq_pkg::TIME_W-1:0]    out_served_time,
  output logic [cpq_pkg::ITEMS_W-1:0]   out_items_left,
  output logic                          out_last_result,
  input  logic                          cfg_we,
  input  logic [cpq_pkg::TIME_W-1:0]    cfg_wdata
);
  import cpq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  slot_t                entries_r [QUEUE_DEPTH];
  slot_t                prev_s    [QUEUE_DEPTH];
  slot_t                next_s    [QUEUE_DEPTH];
  slot_t                new_r;
  slot_t                head;
  slot_t                second;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        cls_cnt_r [CLASS_N];
  logic [CW-1:0]        pos;
  logic [CW-1:0]        count_after;
  logic [CW+ITEMS_W-1:0] items_ext;
  logic [TIME_W-1:0]    budget_r;
  logic [TIME_W-1:0]    sum_r;
  logic [SERVED_W-1:0]  served_r;
  logic [TIME_W:0]      sum_a;
  logic [TIME_W+1:0]    sum_b;
  logic                 fits;
  logic                 over_b;

  logic                 out_valid_r;
  result_code_t         code_r;
  slot_t                res_slot_r;
  logic [ITEMS_W-1:0]   items_r;
  logic                 last_r;
  logic                 emit;

  assign head   = entries_r[0];
  assign second = entries_r[1];

  // neighbor views used by the insert and remove shifts
  always_comb begin
    prev_s[0] = new_r;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      prev_s[i] = entries_r[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      next_s[i] = entries_r[i+1];
    end
    next_s[QUEUE_DEPTH-1] = entries_r[QUEUE_DEPTH-1];
  end

  // insert position: items of the same or a higher class stay in front
  always_comb begin
    pos = cls_cnt_r[0];
    for (int c = 1; c < CLASS_N; c++) begin
      if (CLASS_W'(c) <= new_r.cls) begin
        pos = pos + cls_cnt_r[CLASS_W'(c)];
      end
    end
  end

  // budget check on the head and lookahead on the following entry
  assign sum_a  = {1'b0, sum_r} + {1'b0, head.time_units};
  assign fits   = (sum_a <= {1'b0, budget_r});
  assign sum_b  = {1'b0, sum_a} + {2'b00, second.time_units};
  assign over_b = (sum_b > {2'b00, budget_r});

  // status to the controller
  always_comb begin
    stat.out_free    = !out_valid_r || out_ready;
    stat.in_is_drain = (in_command == CMD_DRAIN);
    stat.full        = (count_r == CW'(QUEUE_DEPTH));
    stat.can_serve   = (count_r != '0) && (served_r < SERVED_W'(MAX_RESULTS)) && fits;
    stat.serve_last  = (count_r == CW'(1)) || (served_r == SERVED_W'(MAX_RESULTS - 1)) ||
                       over_b;
  end

  // item count reported with the result
  always_comb begin
    priority if (cmd.insert) begin
      count_after = count_r + CW'(1);
    end else if (cmd.serve) begin
      count_after = count_r - CW'(1);
    end else begin
      count_after = count_r;
    end
    items_ext = {{ITEMS_W{1'b0}}, count_after};
  end

  assign emit = cmd.insert || cmd.reject || cmd.serve || cmd.none;

  // budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      budget_r <= cfg_wdata;
    end
  end

  // counters, running sum and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      served_r    <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CLASS_N; c++) begin
        cls_cnt_r[c] <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        served_r <= '0;
        sum_r    <= '0;
      end
      if (cmd.insert) begin
        count_r              <= count_r + CW'(1);
        cls_cnt_r[new_r.cls] <= cls_cnt_r[new_r.cls] + CW'(1);
      end
      if (cmd.serve) begin
        count_r             <= count_r - CW'(1);
        cls_cnt_r[head.cls] <= cls_cnt_r[head.cls] - CW'(1);
        sum_r               <= sum_a[TIME_W-1:0];
        served_r            <= served_r + SERVED_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // entry array: shift up behind the insert point, shift down on serve
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      new_r <= '{tag: in_item_tag, cls: in_member_class, time_units: in_service_time};
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.insert) begin
        if (CW'(i) > pos) begin
          entries_r[i] <= prev_s[i];
        end else if (CW'(i) == pos) begin
          entries_r[i] <= new_r;
        end
      end else if (cmd.serve) begin
        entries_r[i] <= next_s[i];
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      items_r <= items_ext[ITEMS_W-1:0];
      priority if (cmd.serve) begin
        code_r     <= RES_SERVED;
        res_slot_r <= head;
        last_r     <= stat.serve_last;
      end else if (cmd.insert) begin
        code_r     <= RES_ENQUEUED;
        res_slot_r <= '0;
        last_r     <= 1'b1;
      end else if (cmd.reject) begin
        code_r     <= RES_FULL;
        res_slot_r <= '0;
        last_r     <= 1'b1;
      end else begin
        code_r     <= RES_NONE;
        res_slot_r <= '0;
        last_r     <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_code  = code_r;
  assign out_served_tag   = res_slot_r.tag;
  assign out_served_class = res_slot_r.cls;
  assign out_served_time  = res_slot_r.time_units;
  assign out_items_left   = items_r;
  assign out_last_result  = last_r;

endmodule
`default_nettype wire

[rtl/class_priority_queue_budget_drain_unit.sv]
// top level of the four-class priority queue with budget drain
//
// in_ch carries one command per transfer: enqueue (tag, class, service time)
// or drain. out_ch carries result items; cfg_we/cfg_wdata write time_budget
// (reset 360). It is up to the user to write it only while the block is idle.
// Enqueue: one result. After the input transfer the sequencer moves to its enqueue
// state; once the output register is free it registers the result and returns to
// idle, where the next input can be taken. The insert point comes from four
// per-class counters and the entries shift in place. Drain: the sequencer moves to
// its drain state, then one served item per cycle while the receiver does not stall,
// up to 16. The head entry and the one behind it are checked against the budget,
// which with the item count and the limit of 16 marks the final result. A drain
// that serves nothing gives one result.
// Only one command is worked on at a time; the next input transfer is taken
// while the final result still waits in the output register.
// When the receiver stalls, the result register holds and the sequencer waits.
// Reset empties the queue, sets the budget to 360 and drops any pending result.
// There is no clearing pass: entry contents are only read below the count.
`default_nettype none
module class_priority_queue_budget_drain_unit #(
  parameter int QUEUE_DEPTH = cpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cpq_in_if.sink                     in_ch,
  cpq_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [cpq_pkg::TIME_W-1:0] cfg_wdata
);
  import cpq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  cpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queue storage and result register
  cpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (in_ch.command),
    .in_item_tag      (in_ch.item_tag),
    .in_member_class  (in_ch.member_class),
    .in_service_time  (in_ch.service_time),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_result_code  (out_ch.result_code),
    .out_served_tag   (out_ch.served_tag),
    .out_served_class (out_ch.served_class),
    .out_served_time  (out_ch.served_time),
    .out_items_left   (out_ch.items_left),
    .out_last_result  (out_ch.last_result),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

endmodule
`default_nettype wire

[rtl/cpq_checker.sv]
// port-level checks for the priority queue top level, with bind
`default_nettype none
module cpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_code,
  input logic [7:0]  served_tag,
  input logic [1:0]  served_class,
  input logic [15:0] served_time,
  input logic        last_result
);
  import cpq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(result_code) &&
    $stable(served_tag) && $stable(served_time) && $stable(last_result))
    else $error("result changed while stalled");

  // one command at a time: ready drops after an input transfer
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // only served results can be followed by more results of the same command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_code != RES_SERVED) |-> last_result)
    else $error("non-served result without last flag");

  // non-served results carry no item
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_code != RES_SERVED) |->
    (served_tag == 8'd0) && (served_class == 2'd0) && (served_time == 16'd0))
    else $error("non-served result with item fields set");

endmodule

bind class_priority_queue_budget_drain_unit cpq_checker u_cpq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_code  (out_ch.result_code),
  .served_tag   (out_ch.served_tag),
  .served_class (out_ch.served_class),
  .served_time  (out_ch.served_time),
  .last_result  (out_ch.last_result)
);
`default_nettype wire

[sim/class_priority_queue_budget_drain_unit_tb.sv]
// self-checking testbench for the class priority queue with budget drain
`timescale 1ns / 1ps
module class_priority_queue_budget_drain_unit_tb;
  import cpq_pkg::*;

  // one result as seen on the out channel
  typedef struct packed {
    result_code_t       code;
    logic [TAG_W-1:0]   tag;
    logic [CLASS_W-1:0] cls;
    logic [TIME_W-1:0]  svc;
    logic [ITEMS_W-1:0] left;
    logic               last;
  } result_t;

  // queue model and store of awaited results
  class budget_drain_scoreboard;
    slot_t       stored [QUEUE_DEPTH_DEF];
    int unsigned stored_count;
    logic [TIME_W-1:0] budget;
    result_t     awaited[$];
    int          errors;

    function new();
      stored_count = 0;
      budget = BUDGET_RESET;
      errors = 0;
    endfunction

    function void set_budget(logic [TIME_W-1:0] value);
      budget = value;
    endfunction

    function void push_result(result_code_t code, slot_t s, logic last, int unsigned left);
      result_t r;
      r.code = code;
      r.tag  = s.tag;
      r.cls  = s.cls;
      r.svc  = s.time_units;
      r.left = left[ITEMS_W-1:0];
      r.last = last;
      awaited.push_back(r);
    endfunction

    // work out the results of one accepted command
    function void note_command(cmd_code_t cmd, slot_t item);
      slot_t       blank;
      slot_t       served[$];
      int unsigned pos;
      int unsigned sum;
      int unsigned count_before;
      blank = '0;
      if (cmd == CMD_ENQUEUE) begin
        if (stored_count >= QUEUE_DEPTH_DEF) begin
          push_result(RES_FULL, blank, 1'b1, stored_count);
          return;
        end
        // insert ahead of the first entry of a lower class
        pos = stored_count;
        if (item.cls != 2'd3) begin
          for (int i = 0; i < stored_count; i++) begin
            if (stored[i].cls > item.cls) begin
              pos = i;
              break;
            end
          end
        end
        for (int i = stored_count; i > pos; i--) stored[i] = stored[i-1];
        stored[pos] = item;
        stored_count++;
        push_result(RES_ENQUEUED, blank, 1'b1, stored_count);
      end else begin
        // serve from the head while the running sum fits the budget
        sum = 0;
        count_before = stored_count;
        while (stored_count > 0 && served.size() < MAX_RESULTS) begin
          if (sum + 32'(stored[0].time_units) > 32'(budget)) break;
          sum += 32'(stored[0].time_units);
          served.push_back(stored[0]);
          for (int i = 1; i < stored_count; i++) stored[i-1] = stored[i];
          stored_count--;
        end
        if (served.size() == 0) begin
          push_result(RES_NONE, blank, 1'b1, stored_count);
        end else begin
          foreach (served[i])
            push_result(RES_SERVED, served[i], i == served.size() - 1,
                        count_before - i - 1);
        end
      end
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // compare one result with the oldest awaited one
    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none actual code %0d tag %0h",
                 $time, got.code, got.tag);
        return;
      end
      want = awaited.pop_front();
      check_field("result_code", want.code, got.code);
      check_field("served_tag", want.tag, got.tag);
      check_field("served_class", want.cls, got.cls);
      check_field("served_time", want.svc, got.svc);
      check_field("items_left", want.left, got.left);
      check_field("last_result", want.last, got.last);
    endfunction

    function int unsigned waiting();
      return awaited.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;
  bit                idle_on;
  budget_drain_scoreboard sb;

  cpq_in_if  in_ch();
  cpq_out_if out_ch();

  class_priority_queue_budget_drain_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  function automatic logic [TIME_W-1:0] draw_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, 120));
    endcase
  endfunction

  // one input transfer, preceded by a random gap
  task automatic send_item(input cmd_code_t cmd, input logic [TAG_W-1:0] tag,
                           input logic [CLASS_W-1:0] cls, input logic [TIME_W-1:0] svc);
    int    gap;
    slot_t item;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.item_tag     <= tag;
    in_ch.member_class <= cls;
    in_ch.service_time <= svc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    item.tag = tag;
    item.cls = cls;
    item.time_units = svc;
    sb.note_command(cmd, item);
  endtask

  // stop sending and wait for every awaited result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_budget(input logic [TIME_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_budget(value);
  endtask

  task automatic send_random(input int count, input int drain_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1, 100) <= drain_pct)
        send_item(CMD_DRAIN, TAG_W'($urandom), CLASS_W'($urandom), TIME_W'($urandom));
      else
        send_item(CMD_ENQUEUE, TAG_W'($urandom), CLASS_W'($urandom), draw_time());
    end
  endtask

  // result side: random stall, then take one transfer
  initial begin
    result_t got;
    int      stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.code = result_code_t'(out_ch.result_code);
      got.tag  = out_ch.served_tag;
      got.cls  = out_ch.served_class;
      got.svc  = out_ch.served_time;
      got.left = out_ch.items_left;
      got.last = out_ch.last_result;
      sb.check_result(got);
    end
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("[class_priority_queue_budget_drain_unit] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    logic [TIME_W-1:0] budgets [6];
    sb = new();
    idle_on = 1'b1;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_ENQUEUE;
    in_ch.item_tag     <= '0;
    in_ch.member_class <= '0;
    in_ch.service_time <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drain of an empty queue
    send_item(CMD_DRAIN, 8'h00, 2'd0, 16'd0);
    // one item per class, tail first
    send_item(CMD_ENQUEUE, 8'h00, 2'd3, 16'd1);
    send_item(CMD_ENQUEUE, 8'hFF, 2'd2, 16'd260);
    send_item(CMD_ENQUEUE, 8'h5A, 2'd1, 16'd0);
    send_item(CMD_ENQUEUE, 8'hA5, 2'd0, 16'd100);
    // reset budget: sum reaches the budget exactly, last item stays
    send_item(CMD_DRAIN, 8'h00, 2'd0, 16'd0);
    // fill to capacity with ties in every class
    for (int i = 0; i < 15; i++)
      send_item(CMD_ENQUEUE, TAG_W'(8'h10 + i), 2'(i % 4),
                (i % 4 == 0) ? 16'd0 : (i == 13) ? 16'hFFFF : 16'(3 * (i + 1)));
    // full queue rejects
    send_item(CMD_ENQUEUE, 8'hFF, 2'd0, 16'hFFFF);
    // zero budget serves only zero-time items
    write_budget(16'd0);
    send_item(CMD_DRAIN, 8'h00, 2'd0, 16'd0);
    // widest budget, stops at the largest item then serves it alone
    write_budget(16'hFFFF);
    send_item(CMD_DRAIN, 8'hFF, 2'd3, 16'hFFFF);
    send_item(CMD_DRAIN, 8'h00, 2'd0, 16'd0);

    // random phases over several budgets
    budgets[0] = BUDGET_RESET;
    budgets[1] = 16'd0;
    budgets[2] = 16'hFFFF;
    budgets[3] = 16'($urandom_range(1, 600));
    budgets[4] = 16'($urandom);
    budgets[5] = 16'($urandom_range(100, 400));
    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      idle_on = (p % 3 != 1);
      send_random(34, (p == 1) ? 45 : 30);
    end

    // drain everything and let the block settle
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("[class_priority_queue_budget_drain_unit] OK");
    else
      $display("[class_priority_queue_budget_drain_unit] ERROR");
    $finish;
  end

endmodule
